@@ rtl/rfc_pkg.sv @@
// rfc_pkg: shared types, marker constants and the float range test
// for the response frame checker
// no dependencies

package rfc_pkg;

    localparam logic [7:0] START_MARK = 8'h3d;
    localparam logic [7:0] END_MARK   = 8'h3e;
    localparam logic [7:0] ESC_MARK   = 8'h1b;

    // magnitude of -100.0 and bit pattern of +500.0 as ieee single
    localparam logic [30:0] NEG100_MAG  = 31'h42C8_0000;
    localparam logic [30:0] POS500_BITS = 31'h43FA_0000;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_FRAME = 2'd1,
        ST_CSUM  = 2'd2
    } t_status;

    typedef struct packed {
        t_status     frame_status;
        logic [31:0] value_bits;
        logic        value_in_range;
        logic [7:0]  status_value;
    } t_result;

    // sign and magnitude compare against the open interval (-100, 500)
    function automatic logic in_range(input logic [31:0] bits);
        logic result;
        if (bits[31]) begin
            result = (bits[30:0] < NEG100_MAG);
        end else begin
            result = (bits[30:0] < POS500_BITS);
        end
        return result;
    endfunction

endpackage

@@ rtl/rfc_frame_core.sv @@
// rfc_frame_core: per-frame state (escape, xor, position, captured word)
// and the end-of-frame result logic
// depends on rfc_pkg

module rfc_frame_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_kind,
    output rfc_pkg::t_result     o_result
);

    logic        r_awaiting, n_awaiting;
    logic        r_start_ok, n_start_ok;
    logic        r_esc,      n_esc;
    logic [7:0]  r_xor,      n_xor;
    logic [2:0]  r_pos,      n_pos;
    logic [31:0] r_value,    n_value;
    logic [7:0]  r_rec0,     n_rec0;
    logic [7:0]  r_rec1,     n_rec1;
    logic        r_has_mid,  n_has_mid;
    logic        r_kind,     n_kind;

    logic        w_take;
    logic [7:0]  w_mid;
    logic [2:0]  w_pos_inc;
    rfc_pkg::t_status w_status;

    assign w_pos_inc = (r_pos == 3'd7) ? r_pos : r_pos + 3'd1;

    always_comb begin
        n_awaiting = r_awaiting;
        n_start_ok = r_start_ok;
        n_esc      = r_esc;
        n_xor      = r_xor;
        n_pos      = r_pos;
        n_value    = r_value;
        n_rec0     = r_rec0;
        n_rec1     = r_rec1;
        n_has_mid  = r_has_mid;
        n_kind     = r_kind;
        w_take     = 1'b0;
        w_mid      = i_byte;
        w_status   = rfc_pkg::ST_FRAME;
        o_result   = '0;

        if (r_awaiting) begin
            n_start_ok = (i_byte == rfc_pkg::START_MARK);
            n_kind     = i_kind;
            n_esc      = 1'b0;
            n_xor      = 8'h00;
            n_pos      = 3'd0;
            n_value    = 32'h0;
            n_rec0     = i_byte;
            n_rec1     = 8'h00;
            n_has_mid  = 1'b0;
            n_awaiting = i_last;
            o_result.frame_status = rfc_pkg::ST_FRAME;
        end else if (!i_last) begin
            if (r_esc) begin
                n_esc  = 1'b0;
                w_take = 1'b1;
                w_mid  = ~i_byte;
            end else if (i_byte == rfc_pkg::ESC_MARK) begin
                n_esc = 1'b1;
            end else begin
                w_take = 1'b1;
            end
            if (w_take) begin
                n_xor     = r_xor ^ w_mid;
                n_rec1    = r_rec0;
                n_rec0    = w_mid;
                n_has_mid = 1'b1;
                n_pos     = w_pos_inc;
                case (w_pos_inc)
                    3'd3:    n_value[7:0]   = r_value[7:0]   | w_mid;
                    3'd4:    n_value[15:8]  = r_value[15:8]  | w_mid;
                    3'd5:    n_value[23:16] = r_value[23:16] | w_mid;
                    3'd6:    n_value[31:24] = r_value[31:24] | w_mid;
                    default: n_value        = r_value;
                endcase
            end
        end else begin
            if (!r_start_ok || i_byte != rfc_pkg::END_MARK || (!r_has_mid && !r_esc)) begin
                w_status = rfc_pkg::ST_FRAME;
            end else if (r_esc || r_xor != 8'h00) begin
                w_status = rfc_pkg::ST_CSUM;
            end else begin
                w_status = rfc_pkg::ST_GOOD;
            end
            o_result.frame_status = w_status;
            if (w_status == rfc_pkg::ST_GOOD) begin
                o_result.value_bits     = r_value;
                o_result.value_in_range = !r_kind && rfc_pkg::in_range(r_value);
                o_result.status_value   = r_rec1;
            end
            n_awaiting = 1'b1;
            n_esc      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b1;
            r_start_ok <= 1'b0;
            r_esc      <= 1'b0;
            r_xor      <= 8'h00;
            r_pos      <= 3'd0;
            r_value    <= 32'h0;
            r_rec0     <= 8'h00;
            r_rec1     <= 8'h00;
            r_has_mid  <= 1'b0;
            r_kind     <= 1'b0;
        end else if (i_step) begin
            r_awaiting <= n_awaiting;
            r_start_ok <= n_start_ok;
            r_esc      <= n_esc;
            r_xor      <= n_xor;
            r_pos      <= n_pos;
            r_value    <= n_value;
            r_rec0     <= n_rec0;
            r_rec1     <= n_rec1;
            r_has_mid  <= n_has_mid;
            r_kind     <= n_kind;
        end
    end

endmodule

@@ rtl/response_frame_checker.sv @@
// response_frame_checker: top level with input register, frame core and
// result register on stream handshakes
// depends on rfc_pkg and rfc_frame_core

// Checks response frames streamed in one byte per request. A frame opens
// with 0x3d and closes with the byte flagged by tlast, which must be 0x3e;
// between them 0x1b escapes the next byte, which is then taken inverted.
// The last unescaped middle byte is a checksum that must make the xor of
// all middle bytes zero. On the end marker one result request is produced
// with status, the little-endian word at unescaped positions 3..6, a flag
// for a float kind value strictly inside (-100, 500), and the byte before
// the checksum; fields other than status are zero for a bad frame. No
// result comes for any other byte. Throughput is one byte per cycle: the
// accepted byte sits in an input register, one pass of the frame core
// updates its state, and an end marker's result is registered in the
// output register as it leaves the input register. Only an end marker waits,
// and only while the previous result is still not taken at the output.

module response_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,   // last_byte
    input  logic [0:0]  i_s_tuser,   // [0] response_kind
    // result request
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [1:0] frame_status, [33:2] value_bits,
                                     // [34] value_in_range, [42:35] status_value,
                                     // [47:43] zero
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_kind;

    // result register
    logic             r_out_valid;
    rfc_pkg::t_result r_out;

    rfc_pkg::t_result w_res;
    logic             w_advance;
    logic             w_in_take;

    // a non-final byte never produces a result, so only an end marker
    // has to wait for the result register to free up
    assign w_advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
            r_in_kind <= i_s_tuser[0];
        end
    end

    rfc_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_kind   (r_in_kind),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.status_value, r_out.value_in_range,
                         r_out.value_bits, r_out.frame_status};

    // a fresh result only follows an end marker leaving the input register
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in_last))
        else $error("result appeared without an end marker");

    // a pending result is never overwritten by the next end marker
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(w_advance && r_in_last))
        else $error("pending result overwritten");

    // bad frames carry zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status != rfc_pkg::ST_GOOD)
        |-> (r_out.value_bits == 32'h0 && !r_out.value_in_range
             && r_out.status_value == 8'h00))
        else $error("bad frame result has nonzero fields");

    // a middle byte in the input register never stalls the input side
    a_no_stall_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> o_s_tready)
        else $error("middle byte stalled");

endmodule
